>>> hdl/twsrtc_pkg.sv
// shared types, codes and a helper function for the three-wire serial rtc interface
`default_nettype none
package twsrtc_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;
    localparam int ITEM_W      = 68;

    localparam logic [7:0] LATCH_MASK    = 8'hF8;
    localparam logic [3:0] CMD_NIBBLE_LS = 4'h6;
    localparam logic [7:0] GBA_CTL_WR    = 8'h6A;
    localparam logic [7:0] NDS_CTL_WR    = 8'h0E;
    localparam logic [7:0] NDS_RESET_BIT = 8'h01;
    localparam logic [3:0] DIR_MASK      = 4'hF;
    localparam logic [6:0] BIT_COUNT_MAX = 7'd64;
    localparam logic [6:0] SNAP_BIT      = 7'd8;
    localparam logic [3:0] SNAP_LAST     = 4'd6;

    // bus access codes
    typedef enum logic [2:0] {
        CMD_PORT_WR = 3'd0,
        CMD_PORT_RD = 3'd1,
        CMD_GP_WR   = 3'd2,
        CMD_GP_DIR  = 3'd3,
        CMD_GP_RD   = 3'd4
    } t_cmd;

    // register indexes in the serial command byte
    localparam logic [2:0] REG_NDS_CTL  = 3'd0;
    localparam logic [2:0] REG_GBA_RST  = 3'd0;
    localparam logic [2:0] REG_GBA_CTL  = 3'd1;
    localparam logic [2:0] REG_DATETIME = 3'd2;
    localparam logic [2:0] REG_TIME     = 3'd3;

    // snapshot byte positions
    localparam logic [2:0] SNAP_YEAR   = 3'd0;
    localparam logic [2:0] SNAP_MONTH  = 3'd1;
    localparam logic [2:0] SNAP_DAY    = 3'd2;
    localparam logic [2:0] SNAP_WDAY   = 3'd3;
    localparam logic [2:0] SNAP_HOUR   = 3'd4;
    localparam logic [2:0] SNAP_MINUTE = 3'd5;
    localparam logic [2:0] SNAP_SECOND = 3'd6;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [6:0]  year;
        logic [15:0] mask;
        logic [15:0] data;
        logic [2:0]  cmd;
    } t_item;

    typedef struct packed {
        logic       sio_line;
        logic       sck_line;
        logic       cs_line;
        logic [7:0] read_data;
    } t_result;

    // binary to bcd for values below 100, tens by reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        begin
            p    = 15'(v) * 15'd205;
            tens = p[14:11];
            ones = v - 7'(7'(tens) * 7'd10);
            return {tens, ones[3:0]};
        end
    endfunction

endpackage
`default_nettype wire

>>> hdl/twsrtc_in_stage.sv
// input register: unpacks and holds one bus access transaction
`default_nettype none
module twsrtc_in_stage
    import twsrtc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [IN_TDATA_W-1:0] i_data,   // cmd, data, mask, year, month, day, hour,
                                                 // minute, second, zero pad
    output logic                       o_ready,
    input  wire logic                  i_take,
    output logic                       o_item_valid,
    output t_item                      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready      = !r_valid || i_take;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= t_item'(i_data[ITEM_W-1:0]);
        end
    end

endmodule
`default_nettype wire

>>> hdl/twsrtc_core.sv
// serial clock chip state and the per-access update of lines, command and registers
`default_nettype none
module twsrtc_core
    import twsrtc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    input  wire logic i_fire,
    input  t_item     i_item,
    output t_result   o_result
);

    logic       r_gba;
    logic [7:0] r_cb;
    logic [6:0] r_bc;
    logic [7:0] r_ctl;
    logic [7:0] r_latch;
    logic [3:0] r_dir;
    logic       r_cs, r_sck, r_sio;
    logic [7:0] r_snap [0:6];

    logic [7:0] n_cb;
    logic [6:0] n_bc;
    logic [7:0] n_ctl;
    logic [7:0] n_latch;
    logic [3:0] n_dir;
    logic       n_cs, n_sck, n_sio;
    logic       n_snap_we;
    logic [7:0] n_snap [0:6];

    logic       drive;
    logic       d_cs, d_sck, d_sio;
    logic       sio_out;
    logic       clr;
    logic [7:0] rd;
    logic [7:0] cb_tmp;
    logic [7:0] cb_rev;
    logic [2:0] idx;
    logic [2:0] pos;
    logic [3:0] byte_no;
    logic [3:0] sel;
    logic [7:0] pos_bit;
    logic [6:0] bc_base;
    logic [6:0] year_m;
    logic [4:0] hour_m;
    logic       pm;
    logic       h24;

    // fresh snapshot from the time inputs
    always_comb begin
        year_m = (i_item.year >= 7'd100) ? (i_item.year - 7'd100) : i_item.year;
        pm     = (i_item.hour >= 5'd12);
        h24    = r_gba ? r_ctl[6] : r_ctl[1];
        hour_m = i_item.hour;
        if (!h24) begin
            if (i_item.hour >= 5'd24) begin
                hour_m = i_item.hour - 5'd24;
            end else if (i_item.hour >= 5'd12) begin
                hour_m = i_item.hour - 5'd12;
            end
        end
        n_snap[SNAP_YEAR]   = to_bcd(year_m);
        n_snap[SNAP_MONTH]  = to_bcd({3'd0, i_item.month});
        n_snap[SNAP_DAY]    = to_bcd({2'd0, i_item.day});
        n_snap[SNAP_WDAY]   = 8'h00;
        n_snap[SNAP_HOUR]   = to_bcd({2'd0, hour_m});
        n_snap[SNAP_MINUTE] = to_bcd({1'b0, i_item.minute});
        n_snap[SNAP_SECOND] = to_bcd({1'b0, i_item.second});
        if (pm) begin
            if (r_gba) begin
                n_snap[SNAP_HOUR][7] = 1'b1;
            end else begin
                n_snap[SNAP_HOUR][6] = 1'b1;
            end
        end
    end

    always_comb begin
        n_cb      = r_cb;
        n_bc      = r_bc;
        n_ctl     = r_ctl;
        n_latch   = r_latch;
        n_dir     = r_dir;
        n_cs      = r_cs;
        n_sck     = r_sck;
        n_sio     = r_sio;
        n_snap_we = 1'b0;
        drive     = 1'b0;
        d_cs      = r_cs;
        d_sck     = r_sck;
        d_sio     = r_sio;
        sio_out   = 1'b0;
        clr       = 1'b0;
        rd        = 8'h00;
        cb_tmp    = 8'h00;
        cb_rev    = 8'h00;
        sel       = 4'd0;
        bc_base   = 7'd0;
        idx       = r_cb[3:1];
        pos       = r_bc[2:0];
        byte_no   = r_bc[6:3];
        pos_bit   = 8'(1) << pos;

        case (i_item.cmd)
            CMD_PORT_WR: begin
                n_latch = i_item.data[7:0] & LATCH_MASK;
                d_cs    = n_latch[6] ? i_item.data[2] : r_cs;
                d_sck   = n_latch[5] ? ~i_item.data[1] : r_sck;
                d_sio   = n_latch[4] ? i_item.data[0] : r_sio;
                drive   = 1'b1;
            end
            CMD_PORT_RD: begin
                rd = {r_latch[7:3], r_cs, r_latch[5] ? 1'b0 : r_sck,
                      r_latch[4] ? 1'b0 : r_sio};
            end
            CMD_GP_WR: begin
                if (|i_item.mask[7:0]) begin
                    d_cs  = r_dir[2] ? i_item.data[2] : r_cs;
                    d_sio = r_dir[1] ? i_item.data[1] : r_sio;
                    d_sck = r_dir[0] ? i_item.data[0] : r_sck;
                    drive = 1'b1;
                end
            end
            CMD_GP_DIR: begin
                n_dir = ((r_dir & ~i_item.mask[3:0]) | (i_item.data[3:0] & i_item.mask[3:0]))
                        & DIR_MASK;
            end
            CMD_GP_RD: begin
                rd = {5'd0, r_dir[2] ? 1'b0 : r_cs, r_dir[1] ? 1'b0 : r_sio,
                      r_dir[0] ? 1'b0 : r_sck};
            end
            default: begin
            end
        endcase

        if (drive) begin
            sio_out = d_sio;
            if (d_cs) begin
                if (!r_sck && d_sck) begin
                    if (r_bc < SNAP_BIT) begin
                        // command bits arrive msb first
                        cb_tmp = r_cb | (8'(d_sio) << (3'd7 - pos));
                        for (int i = 0; i < 8; i++) begin
                            cb_rev[i] = cb_tmp[7-i];
                        end
                        if (pos == 3'd7 && cb_tmp[7:4] != CMD_NIBBLE_LS) begin
                            n_cb = cb_rev;
                        end else begin
                            n_cb = cb_tmp;
                        end
                    end else if (r_cb[0]) begin
                        if (r_gba && idx == REG_GBA_RST) begin
                            clr     = 1'b1;
                            sio_out = 1'b0;
                        end else if ((r_gba && idx == REG_GBA_CTL)
                                     || (!r_gba && idx == REG_NDS_CTL)) begin
                            sio_out = r_ctl[pos];
                        end else if (idx == REG_DATETIME || idx == REG_TIME) begin
                            n_snap_we = (r_bc == SNAP_BIT);
                            sel = (idx == REG_DATETIME) ? (byte_no - 4'd1) : (byte_no + 4'd3);
                            if (sel > SNAP_LAST) begin
                                sio_out = 1'b0;
                            end else if (n_snap_we) begin
                                sio_out = n_snap[sel[2:0]][pos];
                            end else begin
                                sio_out = r_snap[sel[2:0]][pos];
                            end
                        end else begin
                            sio_out = 1'b0;
                        end
                    end else begin
                        if (r_gba) begin
                            if (idx == REG_GBA_CTL && |(pos_bit & GBA_CTL_WR)) begin
                                n_ctl[pos] = d_sio;
                            end
                        end else if (idx == REG_NDS_CTL) begin
                            if (|(pos_bit & NDS_RESET_BIT) && d_sio) begin
                                clr = 1'b1;
                            end else if (|(pos_bit & NDS_CTL_WR)) begin
                                n_ctl[pos] = d_sio;
                            end
                        end
                    end
                    // status reset still lets the current bit complete
                    bc_base = clr ? 7'd0 : r_bc;
                    n_bc    = (bc_base < BIT_COUNT_MAX) ? (bc_base + 7'd1) : bc_base;
                    if (clr) begin
                        n_cb    = 8'h00;
                        n_ctl   = 8'h00;
                        n_latch = 8'h00;
                        n_dir   = 4'h0;
                    end
                end
            end else begin
                n_bc = 7'd0;
                n_cb = 8'h00;
            end
            n_cs  = d_cs;
            n_sck = d_sck;
            n_sio = sio_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gba <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_gba <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb    <= 8'h00;
            r_bc    <= 7'd0;
            r_ctl   <= 8'h00;
            r_latch <= 8'h00;
            r_dir   <= 4'h0;
            r_cs    <= 1'b0;
            r_sck   <= 1'b0;
            r_sio   <= 1'b0;
            for (int i = 0; i < 7; i++) begin
                r_snap[i] <= 8'h00;
            end
        end else if (i_fire) begin
            r_cb    <= n_cb;
            r_bc    <= n_bc;
            r_ctl   <= n_ctl;
            r_latch <= n_latch;
            r_dir   <= n_dir;
            r_cs    <= n_cs;
            r_sck   <= n_sck;
            r_sio   <= n_sio;
            if (n_snap_we) begin
                for (int i = 0; i < 7; i++) begin
                    r_snap[i] <= n_snap[i];
                end
            end
        end
    end

    assign o_result.read_data = rd;
    assign o_result.cs_line   = n_cs;
    assign o_result.sck_line  = n_sck;
    assign o_result.sio_line  = n_sio;

    a_bc_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bc <= BIT_COUNT_MAX)
        else $error("bit count above saturation");

    a_cs_low_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cs |-> (r_bc == 7'd0 && r_cb == 8'h00))
        else $error("serial state not cleared while cs low");

    a_bc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_bc) && $stable(r_cb) && $stable(r_ctl))
        else $error("chip state moved without a transaction");

    a_bc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> (r_bc == $past(r_bc) || r_bc == 7'($past(r_bc) + 7'd1) || r_bc <= 7'd1))
        else $error("bit count jumped");

endmodule
`default_nettype wire

>>> hdl/twsrtc_out_stage.sv
// result register between the update logic and the output stream
`default_nettype none
module twsrtc_out_stage
    import twsrtc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  t_result                     i_result,
    output logic                        o_can_load,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [OUT_TDATA_W-1:0]      o_data    // read_data, cs_line, sck_line, sio_line,
                                                  // zero pad
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = OUT_TDATA_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

>>> hdl/three_wire_serial_rtc_top.sv
// flow: an accepted access is held in the input register, then its result in the result register
// throughput: one access per cycle while the output stream does not stall; the chip state updates
// in a single pass between the input register and the result register
// reset: synchronous active-low, clears all chip state, the snapshot and gba_mode
// the result register may stall while the input register keeps one more access
`default_nettype none
module three_wire_serial_rtc_top
    import twsrtc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic                   i_cfg_wr_data,   // gba_mode
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // cmd, data, mask, year, month, day,
                                                         // hour, minute, second, zero pad
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata   // read_data, cs_line, sck_line,
                                                         // sio_line, zero pad
);

    t_item   item;
    logic    item_valid;
    logic    can_load;
    logic    fire;
    t_result result;

    assign fire = item_valid && can_load;

    twsrtc_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .i_data       (i_s_axis_tdata),
        .o_ready      (o_s_axis_tready),
        .i_take       (fire),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    twsrtc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_item        (item),
        .o_result      (result)
    );

    twsrtc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (result),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
